>>> rtl/core/gap_pkg.sv
package gap_pkg;

  localparam int MaxSide = 8;
  localparam int NodeDepthDef = 512;
  localparam int CellCount = 64;
  localparam int PathMax = 64;
  localparam int StepCount = 8;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_e;

  typedef logic signed [3:0] step_t;

  localparam step_t StepDx [StepCount] = '{4'sd0, 4'sd0, -4'sd1, 4'sd1,
                                           -4'sd1, -4'sd1, 4'sd1, 4'sd1};
  localparam step_t StepDy [StepCount] = '{-4'sd1, 4'sd1, 4'sd0, 4'sd0,
                                           -4'sd1, 4'sd1, -4'sd1, 4'sd1};

  typedef struct packed {
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic       path_found;
    logic       last;
  } result_t;

  // square of a 4-bit signed difference
  function automatic logic [5:0] sq_diff(input logic signed [3:0] d);
    logic [2:0] a;
    a = d[3] ? 3'(-d) : d[2:0];
    return 6'(a * a);
  endfunction

endpackage

>>> rtl/core/gap_engine.sv
module gap_engine import gap_pkg::*; #(
  parameter int NodeDepth = NodeDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] start_x_i,
  input  logic [2:0] start_y_i,
  input  logic [2:0] goal_x_i,
  input  logic [2:0] goal_y_i,
  input  logic [3:0] cols_i,
  input  logic [3:0] rows_i,
  output logic       idle_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  localparam int IW = $clog2(NodeDepth);
  localparam int CW = IW + 1;
  localparam int GW = IW + 1;
  localparam int FW = IW + 2;

  typedef struct packed {
    logic [2:0]    x;
    logic [2:0]    y;
    logic [GW-1:0] g;
    logic [FW-1:0] f;
    logic [IW-1:0] idx;
  } open_t;

  typedef struct packed {
    logic [2:0]    x;
    logic [2:0]    y;
    logic [IW-1:0] parent;
    logic          root;
  } node_t;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SEL_RD   = 12'b000000000010,
    S_SEL_CMP  = 12'b000000000100,
    S_DEL_RD   = 12'b000000001000,
    S_DEL_WR   = 12'b000000010000,
    S_CHECK    = 12'b000000100000,
    S_KID      = 12'b000001000000,
    S_DUP_RD   = 12'b000010000000,
    S_DUP_CMP  = 12'b000100000000,
    S_ADD      = 12'b001000000000,
    S_PATH_RD  = 12'b010000000000,
    S_PATH_OUT = 12'b100000000000
  } state_e;
  // not-found result leaves through the path output state with fail set
  localparam state_e S_FAIL_ALIAS = S_PATH_OUT;

  open_t open_mem [NodeDepth];
  node_t node_mem [NodeDepth];
  open_t open_rd_q;
  node_t node_rd_q;

  state_e state_q, state_d;
  logic   fail_q, fail_d;
  logic [CW-1:0] i_q, i_d, node_cnt_q, node_cnt_d, open_cnt_q, open_cnt_d;
  open_t cur_q, cur_d;
  logic [3:0] k_q, k_d;
  logic [2:0] kx_q, kx_d, ky_q, ky_d;
  logic [GW-1:0] kg_q, kg_d;
  logic [FW-1:0] kf_q, kf_d;
  logic [CellCount-1:0] closed_q, closed_d;
  logic [2:0] gx_q, gx_d, gy_q, gy_d;
  logic [3:0] cols_q, cols_d, rows_q, rows_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic [5:0] n_q, n_d;

  logic [IW-1:0] open_raddr;
  logic          open_we, node_we;
  logic [IW-1:0] open_waddr, node_waddr;
  open_t         open_wdata;
  node_t         node_wdata;

  logic [StepCount-1:0] kid_ok;
  logic [3:0] nx_s [StepCount];
  logic [3:0] ny_s [StepCount];
  logic [2:0] kk;
  logic [GW-1:0] g_new;
  logic take;
  open_t best_new;

  always_comb begin
    for (int s = 0; s < StepCount; s++) begin
      nx_s[s] = {1'b0, cur_q.x} + StepDx[s];
      ny_s[s] = {1'b0, cur_q.y} + StepDy[s];
      kid_ok[s] = !nx_s[s][3] && !ny_s[s][3] && (nx_s[s] < cols_q) && (ny_s[s] < rows_q);
    end
  end

  assign kk    = k_q[2:0];
  assign g_new = cur_q.g + GW'(1);
  assign take  = (i_q == '0) || (open_rd_q.f < cur_q.f);
  assign best_new = take ? open_rd_q : cur_q;

  always_comb begin
    unique case (state_q)
      S_DEL_RD: open_raddr = IW'(i_q + CW'(1));
      default:  open_raddr = i_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_waddr] <= open_wdata;
    open_rd_q <= open_mem[open_raddr];
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd_q <= node_mem[pidx_q];
  end

  always_comb begin
    state_d = state_q;  fail_d = fail_q;  i_d = i_q;
    node_cnt_d = node_cnt_q;  open_cnt_d = open_cnt_q;  cur_d = cur_q;
    k_d = k_q;  kx_d = kx_q;  ky_d = ky_q;  kg_d = kg_q;  kf_d = kf_q;
    closed_d = closed_q;  gx_d = gx_q;  gy_d = gy_q;
    cols_d = cols_q;  rows_d = rows_q;  pidx_d = pidx_q;  n_d = n_q;
    open_we = 1'b0;  open_waddr = '0;  open_wdata = '0;
    node_we = 1'b0;  node_waddr = '0;  node_wdata = '0;
    res_valid_o = 1'b0;
    res_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          gx_d = goal_x_i;  gy_d = goal_y_i;
          cols_d = (cols_i > 4'(MaxSide)) ? 4'(MaxSide) : cols_i;
          rows_d = (rows_i > 4'(MaxSide)) ? 4'(MaxSide) : rows_i;
          node_we = 1'b1;
          node_wdata = '{x: start_x_i, y: start_y_i, parent: '0, root: 1'b1};
          open_we = 1'b1;
          open_wdata = '{x: start_x_i, y: start_y_i, g: '0, f: '0, idx: '0};
          node_cnt_d = CW'(1);  open_cnt_d = CW'(1);
          closed_d = '0;  fail_d = 1'b0;  i_d = '0;
          state_d = S_SEL_RD;
        end
      end
      S_SEL_RD: begin
        if (open_cnt_q == '0) begin
          fail_d = 1'b1;
          state_d = S_FAIL_ALIAS;
        end else begin
          state_d = S_SEL_CMP;
        end
      end
      S_SEL_CMP: begin
        cur_d = best_new;
        if (take) pidx_d = i_q[IW-1:0];
        if (i_q + CW'(1) == open_cnt_q) begin
          i_d = take ? i_q : {1'b0, pidx_q};
          state_d = S_DEL_RD;
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_SEL_RD;
        end
      end
      S_DEL_RD: begin
        if (i_q + CW'(1) == open_cnt_q) begin
          open_cnt_d = open_cnt_q - CW'(1);
          closed_d[{cur_q.y, cur_q.x}] = 1'b1;
          state_d = S_CHECK;
        end else begin
          state_d = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        open_we = 1'b1;
        open_waddr = i_q[IW-1:0];
        open_wdata = open_rd_q;
        i_d = i_q + CW'(1);
        state_d = S_DEL_RD;
      end
      S_CHECK: begin
        if (cur_q.x == gx_q && cur_q.y == gy_q) begin
          pidx_d = cur_q.idx;  n_d = '0;
          state_d = S_PATH_RD;
        end else if (kid_ok == '0) begin
          fail_d = 1'b1;
          state_d = S_FAIL_ALIAS;
        end else begin
          k_d = '0;
          state_d = S_KID;
        end
      end
      S_KID: begin
        if (k_q[3]) begin
          i_d = '0;
          state_d = S_SEL_RD;
        end else if (!kid_ok[kk] || closed_q[{ny_s[kk][2:0], nx_s[kk][2:0]}]) begin
          k_d = k_q + 4'd1;
        end else begin
          kx_d = nx_s[kk][2:0];
          ky_d = ny_s[kk][2:0];
          kg_d = g_new;
          kf_d = FW'(g_new) + FW'(sq_diff(4'(nx_s[kk]) - 4'({1'b0, gx_q})))
               + FW'(sq_diff(4'(ny_s[kk]) - 4'({1'b0, gy_q})));
          i_d = '0;
          state_d = (open_cnt_q == '0) ? S_ADD : S_DUP_RD;
        end
      end
      S_DUP_RD: state_d = S_DUP_CMP;
      S_DUP_CMP: begin
        if (open_rd_q.x == kx_q && open_rd_q.y == ky_q && kg_q > open_rd_q.g) begin
          k_d = k_q + 4'd1;
          state_d = S_KID;
        end else if (i_q + CW'(1) == open_cnt_q) begin
          state_d = S_ADD;
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_DUP_RD;
        end
      end
      S_ADD: begin
        if (node_cnt_q == CW'(NodeDepth)) begin
          fail_d = 1'b1;
          state_d = S_FAIL_ALIAS;
        end else begin
          node_we = 1'b1;
          node_waddr = node_cnt_q[IW-1:0];
          node_wdata = '{x: kx_q, y: ky_q, parent: cur_q.idx, root: 1'b0};
          open_we = 1'b1;
          open_waddr = open_cnt_q[IW-1:0];
          open_wdata = '{x: kx_q, y: ky_q, g: kg_q, f: kf_q, idx: node_cnt_q[IW-1:0]};
          node_cnt_d = node_cnt_q + CW'(1);
          open_cnt_d = open_cnt_q + CW'(1);
          k_d = k_q + 4'd1;
          state_d = S_KID;
        end
      end
      S_PATH_RD: state_d = S_PATH_OUT;
      S_PATH_OUT: begin
        res_valid_o = 1'b1;
        if (fail_q) begin
          res_o = '{cell_x: '0, cell_y: '0, path_found: 1'b0, last: 1'b1};
          if (res_ready_i) state_d = S_IDLE;
        end else begin
          res_o = '{cell_x: node_rd_q.x, cell_y: node_rd_q.y, path_found: 1'b1,
                    last: node_rd_q.root || (n_q == 6'(PathMax - 1))};
          if (res_ready_i) begin
            if (res_o.last) begin
              state_d = S_IDLE;
            end else begin
              pidx_d = node_rd_q.parent;
              n_d = n_q + 6'd1;
              state_d = S_PATH_RD;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fail_q     <= 1'b0;
      node_cnt_q <= '0;
      open_cnt_q <= '0;
      closed_q   <= '0;
      cols_q     <= 4'(MaxSide);
      rows_q     <= 4'(MaxSide);
    end else begin
      state_q    <= state_d;
      fail_q     <= fail_d;
      node_cnt_q <= node_cnt_d;
      open_cnt_q <= open_cnt_d;
      closed_q   <= closed_d;
      cols_q     <= cols_d;
      rows_q     <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  cur_q <= cur_d;  k_q <= k_d;
    kx_q <= kx_d;  ky_q <= ky_d;  kg_q <= kg_d;  kf_q <= kf_d;
    gx_q <= gx_d;  gy_q <= gy_d;  pidx_q <= pidx_d;  n_q <= n_d;
  end

endmodule

>>> rtl/core/grid_astar_path_search_top.sv
// channel  | dir | tdata (low bit up)                 | tuser      | tlast
// s_axis   | in  | start_x, start_y, goal_x, goal_y   | -          | -
// m_axis   | out | cell_x, cell_y, zero pad           | path_found | last
// cfg      | in  | index 0 column_count, 1 row_count  | -          | -
// A request takes longer as the open list grows: each selection reads every open
// entry, the entries behind the chosen one are shifted down, each child is tested,
// and each child in the grid and not closed scans the open list for a duplicate,
// all through one port of the open memory; the path is then walked out cell by cell.
// s_axis_tready is low from the accepted transfer until the last result leaves
// the engine. An output register parts the engine from m_axis, so a stalled
// sink only holds the path walk. Reset clears control and sets both counts to 8.
module grid_astar_path_search_top import gap_pkg::*; #(
  parameter int NodeDepth = NodeDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // start_x, start_y, goal_x, goal_y, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // cell_x, cell_y, pad
  output logic        m_axis_tuser,   // path_found
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);

  logic [3:0] cols_q, rows_q;
  logic       idle, res_valid, res_ready, out_valid_q;
  result_t    res, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 4'(MaxSide);
      rows_q <= 4'(MaxSide);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_ROWS: rows_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign s_axis_tready = idle;

  gap_engine #(.NodeDepth(NodeDepth)) u_engine (
    .clk_i,
    .rst_ni,
    .start_i     (s_axis_tvalid && idle),
    .start_x_i   (s_axis_tdata[2:0]),
    .start_y_i   (s_axis_tdata[5:3]),
    .goal_x_i    (s_axis_tdata[8:6]),
    .goal_y_i    (s_axis_tdata[11:9]),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.cell_y, out_q.cell_x};
  assign m_axis_tuser  = out_q.path_found;
  assign m_axis_tlast  = out_q.last;

endmodule
